### rtl/bilinear_raster_sampler_core_defines.svh
// ----------------------------------------------------------------------------
// Bilinear raster sampler assertion macros
// Shared property shapes for the checker; every property samples on clk and
// is disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_RASTER_SAMPLER_CORE_DEFINES_SVH
`define BILINEAR_RASTER_SAMPLER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BRS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/brs_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear raster sampler package
// Field widths, register map, outcome codes and the structs that travel
// between the sampler's modules.
// ----------------------------------------------------------------------------
package brs_pkg;

	// Fixed field widths of the stream words and the register port.
	localparam int POS_BITS      = 18;
	localparam int COORD_BITS    = 8;
	localparam int WSAMPLE_BITS  = 24;
	localparam int ELEV_BITS     = 24;
	localparam int SIZE_BITS     = 9;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_ADDR_BITS = 5;
	localparam int S_TDATA_BITS  = 80;
	localparam int M_TDATA_BITS  = 24;

	// Saturation limits of the elevation result.
	localparam int ELEV_MAX = 8388607;
	localparam int ELEV_MIN = -8388608;

	// Operation carried in the input tuser.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Register indexes (byte address divided by four).
	localparam logic [2:0] REG_WIDTH         = 3'd0;
	localparam logic [2:0] REG_HEIGHT        = 3'd1;
	localparam logic [2:0] REG_NODATA_VALUE  = 3'd2;
	localparam logic [2:0] REG_NODATA_ENABLE = 3'd3;
	localparam logic [2:0] REG_OOR_VALUE     = 3'd4;

	// Register reset values.
	localparam logic [SIZE_BITS-1:0]        RST_WIDTH       = 9'd256;
	localparam logic [SIZE_BITS-1:0]        RST_HEIGHT      = 9'd256;
	localparam logic signed [ELEV_BITS-1:0] RST_NODATA      = -24'sd159984;
	localparam logic                        RST_NODATA_EN   = 1'b0;
	localparam logic signed [ELEV_BITS-1:0] RST_OOR_VALUE   = 24'sd0;

	// Result classification carried in the output tuser.
	typedef enum logic [1:0] {
		OUT_INTERP = 2'd0,
		OUT_SINGLE = 2'd1,
		OUT_RANGE  = 2'd2,
		OUT_NODATA = 2'd3
	} outcome_t;

	typedef struct packed {
		logic signed [ELEV_BITS-1:0] elevation;
		outcome_t                    outcome;
	} result_t;

	// Position decode flags from the locate stage.
	typedef struct packed {
		logic oor;
		logic single;
	} loc_flags_t;

	// Start request to the blend pipeline.
	typedef struct packed {
		logic start;
		logic single;
		logic nodata_en;
	} blend_req_t;

endpackage

### rtl/brs_store.sv
// ----------------------------------------------------------------------------
// Bilinear raster sampler store
// Single-port-write, single-port-read synchronous sample memory with a
// registered read.
// ----------------------------------------------------------------------------
module brs_store #(
	parameter int DEPTH     = 65536,
	parameter int ADDR_BITS = 16,
	parameter int DATA_BITS = 24
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  logic [DATA_BITS-1:0] wr_data,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output logic [DATA_BITS-1:0] rd_data
);

	logic [DATA_BITS-1:0] mem_q [DEPTH];
	logic [DATA_BITS-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port, registered.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/brs_locate.sv
// ----------------------------------------------------------------------------
// Bilinear raster sampler locate stage
// Decodes a query position into the range test, the clamped corner
// coordinates and the fractional offsets, registered at query accept.
// ----------------------------------------------------------------------------
module brs_locate
	import brs_pkg::*;
#(
	parameter int MAX_COLS  = 256,
	parameter int MAX_ROWS  = 256,
	parameter int FRAC_BITS = 8
) (
	input  logic                              clk,
	input  logic                              load,
	input  logic signed [POS_BITS-1:0]        pos_x,
	input  logic signed [POS_BITS-1:0]        pos_y,
	input  logic [SIZE_BITS-1:0]              raster_width,
	input  logic [SIZE_BITS-1:0]              raster_height,
	output loc_flags_t                        flags,
	output logic [$clog2(MAX_COLS)-1:0]       x0,
	output logic [$clog2(MAX_COLS)-1:0]       x1,
	output logic [$clog2(MAX_ROWS)-1:0]       y0,
	output logic [$clog2(MAX_ROWS)-1:0]       y1,
	output logic signed [FRAC_BITS:0]         dx,
	output logic signed [FRAC_BITS:0]         dy
);

	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = $clog2(MAX_ROWS);
	localparam logic [FRAC_BITS-1:0] FRAC_HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);
	localparam logic signed [POS_BITS-1:0] NEG_HALF = POS_BITS'(-(1 << (FRAC_BITS - 1)));

	logic [CW-1:0]                  wlast_x;
	logic [RW-1:0]                  wlast_y;
	logic signed [CW+FRAC_BITS:0]   lim_x;
	logic signed [RW+FRAC_BITS:0]   lim_y;
	logic signed [POS_BITS-1:0]     fl_x;
	logic signed [POS_BITS-1:0]     fl_y;
	logic                           neg_x;
	logic                           neg_y;
	logic [CW-1:0]                  x0_n;
	logic [CW-1:0]                  x1_n;
	logic [RW-1:0]                  y0_n;
	logic [RW-1:0]                  y1_n;
	logic signed [FRAC_BITS:0]      dx_n;
	logic signed [FRAC_BITS:0]      dy_n;
	loc_flags_t                     flags_n;

	loc_flags_t                     flags_q;
	logic [CW-1:0]                  x0_q;
	logic [CW-1:0]                  x1_q;
	logic [RW-1:0]                  y0_q;
	logic [RW-1:0]                  y1_q;
	logic signed [FRAC_BITS:0]      dx_q;
	logic signed [FRAC_BITS:0]      dy_q;

	// Last usable column and row; a zero size acts as one, an oversize as the maximum.
	always_comb begin
		if (raster_width == '0) begin
			wlast_x = '0;
		end else if (int'(raster_width) > MAX_COLS) begin
			wlast_x = CW'(MAX_COLS - 1);
		end else begin
			wlast_x = CW'(raster_width - 1'b1);
		end
		if (raster_height == '0) begin
			wlast_y = '0;
		end else if (int'(raster_height) > MAX_ROWS) begin
			wlast_y = RW'(MAX_ROWS - 1);
		end else begin
			wlast_y = RW'(raster_height - 1'b1);
		end
	end

	// Range test and corner decode. Inside the range the floor corner is at
	// least minus one and at most the last index, so clamping is a small mux.
	always_comb begin
		lim_x = {1'b0, wlast_x, FRAC_HALF};
		lim_y = {1'b0, wlast_y, FRAC_HALF};
		fl_x  = pos_x >>> FRAC_BITS;
		fl_y  = pos_y >>> FRAC_BITS;
		neg_x = pos_x[POS_BITS-1];
		neg_y = pos_y[POS_BITS-1];

		x0_n = neg_x ? '0 : CW'(fl_x);
		y0_n = neg_y ? '0 : RW'(fl_y);
		x1_n = neg_x ? '0 : ((x0_n == wlast_x) ? wlast_x : x0_n + 1'b1);
		y1_n = neg_y ? '0 : ((y0_n == wlast_y) ? wlast_y : y0_n + 1'b1);

		// Offset from the clamped corner; negative only left of or above the raster.
		dx_n = neg_x ? (FRAC_BITS+1)'(pos_x) : {1'b0, pos_x[FRAC_BITS-1:0]};
		dy_n = neg_y ? (FRAC_BITS+1)'(pos_y) : {1'b0, pos_y[FRAC_BITS-1:0]};

		flags_n.oor    = (pos_x < NEG_HALF) || (pos_x > lim_x) ||
		                 (pos_y < NEG_HALF) || (pos_y > lim_y);
		flags_n.single = (x0_n == x1_n) && (y0_n == y1_n);
	end

	// Hold the decode for the fetch sequence.
	always_ff @(posedge clk) begin
		if (load) begin
			flags_q <= flags_n;
			x0_q    <= x0_n;
			x1_q    <= x1_n;
			y0_q    <= y0_n;
			y1_q    <= y1_n;
			dx_q    <= dx_n;
			dy_q    <= dy_n;
		end
	end

	assign flags = flags_q;
	assign x0    = x0_q;
	assign x1    = x1_q;
	assign y0    = y0_q;
	assign y1    = y1_q;
	assign dx    = dx_q;
	assign dy    = dy_q;

endmodule

### rtl/brs_blend.sv
// ----------------------------------------------------------------------------
// Bilinear raster sampler blend pipeline
// Four-stage fixed-point bilinear blend of the corner samples: x products,
// x rounding, y products, y rounding with saturation and outcome selection.
// ----------------------------------------------------------------------------
module brs_blend
	import brs_pkg::*;
#(
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS   = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  blend_req_t                       req,
	input  logic signed [ELEV_BITS-1:0]      nodata_value,
	input  logic signed [SAMPLE_BITS-1:0]    z00,
	input  logic signed [SAMPLE_BITS-1:0]    z01,
	input  logic signed [SAMPLE_BITS-1:0]    z10,
	input  logic signed [SAMPLE_BITS-1:0]    z11,
	input  logic signed [FRAC_BITS:0]        dx,
	input  logic signed [FRAC_BITS:0]        dy,
	output logic                             done,
	output result_t                          result
);

	localparam int WT = FRAC_BITS + 2;          // weight width
	localparam int PW = SAMPLE_BITS + WT;       // x product width
	localparam int PS = PW + 1;                 // x sum width
	localparam int ZW = PS - FRAC_BITS;         // x blend width
	localparam int QW = ZW + WT;                // y product width
	localparam int QS = QW + 1;                 // y sum width
	localparam int RW = QS - FRAC_BITS;         // y blend width
	localparam logic signed [WT-1:0] W_ONE  = WT'(1) <<< FRAC_BITS;
	localparam logic signed [PS-1:0] P_HALF = PS'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [QS-1:0] Q_HALF = QS'(1) <<< (FRAC_BITS - 1);

	logic signed [WT-1:0]          wxa;
	logic signed [WT-1:0]          wxb;
	logic signed [PS-1:0]          sum0;
	logic signed [PS-1:0]          sum1;
	logic signed [QS-1:0]          sum_y;
	logic signed [RW-1:0]          blend_y;
	logic signed [RW-1:0]          pick;
	logic signed [ELEV_BITS-1:0]   elev_sat;

	logic                          v_s1, v_s2, v_s3, v_s4;
	logic signed [PW-1:0]          p0_s1, p1_s1, p2_s1, p3_s1;
	logic signed [WT-1:0]          wya_s1, wyb_s1, wya_s2, wyb_s2;
	logic                          single_s1, single_s2, single_s3;
	logic                          nd_s1, nd_s2, nd_s3;
	logic signed [SAMPLE_BITS-1:0] z00_s1, z00_s2, z00_s3;
	logic signed [ZW-1:0]          z0_s2, z1_s2;
	logic signed [QW-1:0]          q0_s3, q1_s3;
	result_t                       result_s4;

	// Weights from the clamped corner.
	assign wxb = WT'(dx);
	assign wxa = W_ONE - wxb;

	// Rounding sums, halves towards plus infinity.
	assign sum0  = PS'(p0_s1) + PS'(p1_s1) + P_HALF;
	assign sum1  = PS'(p2_s1) + PS'(p3_s1) + P_HALF;
	assign sum_y = QS'(q0_s3) + QS'(q1_s3) + Q_HALF;
	assign blend_y = RW'(sum_y >>> FRAC_BITS);

	// Final selection and saturation.
	always_comb begin
		pick = single_s3 ? RW'(z00_s3) : blend_y;
		if (pick > ELEV_MAX) begin
			elev_sat = ELEV_BITS'(ELEV_MAX);
		end else if (pick < ELEV_MIN) begin
			elev_sat = ELEV_BITS'(ELEV_MIN);
		end else begin
			elev_sat = ELEV_BITS'(pick);
		end
	end

	// Stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: x products and the nodata test.
	always_ff @(posedge clk) begin
		if (req.start) begin
			p0_s1     <= z00 * wxa;
			p1_s1     <= z01 * wxb;
			p2_s1     <= z10 * wxa;
			p3_s1     <= z11 * wxb;
			wyb_s1    <= WT'(dy);
			wya_s1    <= W_ONE - WT'(dy);
			single_s1 <= req.single;
			nd_s1     <= req.nodata_en &&
			             ((z00 == nodata_value) || (z01 == nodata_value) ||
			              (z10 == nodata_value) || (z11 == nodata_value));
			z00_s1    <= z00;
		end
	end

	// Stage 2: round the two row blends.
	always_ff @(posedge clk) begin
		if (v_s1) begin
			z0_s2     <= ZW'(sum0 >>> FRAC_BITS);
			z1_s2     <= ZW'(sum1 >>> FRAC_BITS);
			wya_s2    <= wya_s1;
			wyb_s2    <= wyb_s1;
			single_s2 <= single_s1;
			nd_s2     <= nd_s1;
			z00_s2    <= z00_s1;
		end
	end

	// Stage 3: y products.
	always_ff @(posedge clk) begin
		if (v_s2) begin
			q0_s3     <= z0_s2 * wya_s2;
			q1_s3     <= z1_s2 * wyb_s2;
			single_s3 <= single_s2;
			nd_s3     <= nd_s2;
			z00_s3    <= z00_s2;
		end
	end

	// Stage 4: result word.
	always_ff @(posedge clk) begin
		if (v_s3) begin
			if (nd_s3) begin
				result_s4.elevation <= '0;
				result_s4.outcome   <= OUT_NODATA;
			end else begin
				result_s4.elevation <= elev_sat;
				result_s4.outcome   <= single_s3 ? OUT_SINGLE : OUT_INTERP;
			end
		end
	end

	assign done   = v_s4;
	assign result = result_s4;

endmodule

### rtl/bilinear_raster_sampler_core.sv
// ----------------------------------------------------------------------------
// Bilinear raster sampler core
// Elevation raster held in on-chip memory, loaded by write words and sampled
// by query words with edge clamping and bilinear interpolation.
// ----------------------------------------------------------------------------
// Usage:
// Input words arrive on the s_ stream; tuser selects a sample write (0) or a
// query (1). A write stores one sample and is taken every cycle while the
// sequencer is idle. A query reads its four corners one per cycle from the
// single read port of the raster memory, then runs a four-stage blend
// pipeline. An accepted query holds s_tready low until its result word is
// moved into the output register and offered on m_; an out-of-range query
// skips the corner reads and the blend pipeline. Writes return no word. The
// result sits in an output register, so the input side takes writes and
// queries while it waits; a query that finishes while the receiver stalls
// the previous word waits in its last step until the register frees. Reset
// clears the control and the registers to their defaults; the raster
// contents are undefined until written.
// ----------------------------------------------------------------------------
module bilinear_raster_sampler_core
	import brs_pkg::*;
#(
	parameter int MAX_COLS    = 256,
	parameter int MAX_ROWS    = 256,
	parameter int FRAC_BITS   = 8,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// Input stream.
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// pos_x[17:0], pos_y[35:18], write_col[43:36], write_row[51:44],
	// write_sample[75:52], zero fill [79:76]
	input  logic [S_TDATA_BITS-1:0]  s_tdata,
	// op[0]
	input  logic                     s_tuser,
	// Result stream.
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// elevation[23:0]
	output logic [M_TDATA_BITS-1:0]  m_tdata,
	// outcome[1:0]
	output logic [1:0]               m_tuser,
	// Register port.
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [CFG_DATA_BITS-1:0] pwdata,
	output logic [CFG_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	localparam int CW    = $clog2(MAX_COLS);
	localparam int ROWB  = $clog2(MAX_ROWS);
	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [2:0] STEP_LAST = 3'd4;
	localparam logic signed [32:0] SMP_MAX = (33'sd1 <<< (SAMPLE_BITS - 1)) - 33'sd1;
	localparam logic signed [32:0] SMP_MIN = -(33'sd1 <<< (SAMPLE_BITS - 1));

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_BLEND,
		ST_RESULT
	} state_t;

	// Unpacked input fields.
	logic signed [POS_BITS-1:0]     in_pos_x;
	logic signed [POS_BITS-1:0]     in_pos_y;
	logic [COORD_BITS-1:0]          in_col;
	logic [COORD_BITS-1:0]          in_row;
	logic signed [WSAMPLE_BITS-1:0] in_sample;
	logic                           in_accept;

	// Configuration registers.
	logic [SIZE_BITS-1:0]           raster_width_q;
	logic [SIZE_BITS-1:0]           raster_height_q;
	logic signed [ELEV_BITS-1:0]    nodata_value_q;
	logic                           nodata_enable_q;
	logic signed [ELEV_BITS-1:0]    oor_value_q;
	logic                           cfg_wr;
	logic [2:0]                     cfg_idx;

	// Store ports.
	logic                           wr_en;
	logic [AW-1:0]                  wr_addr;
	logic signed [32:0]             wr_wide;
	logic signed [32:0]             wr_sat;
	logic                           rd_en;
	logic [AW-1:0]                  rd_addr;
	logic [SAMPLE_BITS-1:0]         rd_data;
	logic [CW-1:0]                  rd_col;
	logic [ROWB-1:0]                rd_row;

	// Locate outputs.
	loc_flags_t                     loc_flags;
	logic [CW-1:0]                  loc_x0;
	logic [CW-1:0]                  loc_x1;
	logic [ROWB-1:0]                loc_y0;
	logic [ROWB-1:0]                loc_y1;
	logic signed [FRAC_BITS:0]      loc_dx;
	logic signed [FRAC_BITS:0]      loc_dy;

	// Blend interface.
	blend_req_t                     blend_req;
	logic                           blend_done;
	result_t                        blend_res;

	// Sequencer.
	state_t                         state_q;
	logic [2:0]                     step_q;
	logic [1:0]                     z_idx;
	logic signed [SAMPLE_BITS-1:0]  z_q [3];
	result_t                        res_q;
	result_t                        out_q;
	logic                           m_tvalid_q;
	logic                           out_load;

	// Input word fields.
	assign in_pos_x  = s_tdata[17:0];
	assign in_pos_y  = s_tdata[35:18];
	assign in_col    = s_tdata[43:36];
	assign in_row    = s_tdata[51:44];
	assign in_sample = s_tdata[75:52];
	assign s_tready  = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;

	// Register port: writes in the access phase, reads are combinational.
	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raster_width_q  <= RST_WIDTH;
			raster_height_q <= RST_HEIGHT;
			nodata_value_q  <= RST_NODATA;
			nodata_enable_q <= RST_NODATA_EN;
			oor_value_q     <= RST_OOR_VALUE;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_WIDTH:         raster_width_q  <= pwdata[SIZE_BITS-1:0];
				REG_HEIGHT:        raster_height_q <= pwdata[SIZE_BITS-1:0];
				REG_NODATA_VALUE:  nodata_value_q  <= pwdata[ELEV_BITS-1:0];
				REG_NODATA_ENABLE: nodata_enable_q <= pwdata[0];
				REG_OOR_VALUE:     oor_value_q     <= pwdata[ELEV_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_WIDTH:         prdata = CFG_DATA_BITS'(raster_width_q);
			REG_HEIGHT:        prdata = CFG_DATA_BITS'(raster_height_q);
			REG_NODATA_VALUE:  prdata = CFG_DATA_BITS'(nodata_value_q);
			REG_NODATA_ENABLE: prdata = CFG_DATA_BITS'(nodata_enable_q);
			REG_OOR_VALUE:     prdata = CFG_DATA_BITS'(oor_value_q);
			default:           prdata = '0;
		endcase
	end

	// Sample write: drop positions outside the store, saturate to the sample width.
	always_comb begin
		wr_en   = in_accept && (s_tuser == OP_WRITE) &&
		          (int'(in_col) < MAX_COLS) && (int'(in_row) < MAX_ROWS);
		wr_addr = AW'(AW'(in_row) * AW'(MAX_COLS)) + AW'(in_col);
		wr_wide = 33'(in_sample);
		if (wr_wide > SMP_MAX) begin
			wr_sat = SMP_MAX;
		end else if (wr_wide < SMP_MIN) begin
			wr_sat = SMP_MIN;
		end else begin
			wr_sat = wr_wide;
		end
	end

	// Corner read: step bit 0 picks the column, bit 1 the row.
	assign rd_col  = step_q[0] ? loc_x1 : loc_x0;
	assign rd_row  = step_q[1] ? loc_y1 : loc_y0;
	assign rd_addr = AW'(AW'(rd_row) * AW'(MAX_COLS)) + AW'(rd_col);
	assign rd_en   = (state_q == ST_FETCH) && !loc_flags.oor && (step_q != STEP_LAST);
	assign z_idx   = 2'(step_q - 3'd1);

	brs_store #(
		.DEPTH     (DEPTH),
		.ADDR_BITS (AW),
		.DATA_BITS (SAMPLE_BITS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (SAMPLE_BITS'(wr_sat)),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	brs_locate #(
		.MAX_COLS  (MAX_COLS),
		.MAX_ROWS  (MAX_ROWS),
		.FRAC_BITS (FRAC_BITS)
	) u_locate (
		.clk           (clk),
		.load          (in_accept && (s_tuser == OP_QUERY)),
		.pos_x         (in_pos_x),
		.pos_y         (in_pos_y),
		.raster_width  (raster_width_q),
		.raster_height (raster_height_q),
		.flags         (loc_flags),
		.x0            (loc_x0),
		.x1            (loc_x1),
		.y0            (loc_y0),
		.y1            (loc_y1),
		.dx            (loc_dx),
		.dy            (loc_dy)
	);

	// The last corner comes straight from the read register.
	assign blend_req.start     = (state_q == ST_FETCH) && !loc_flags.oor &&
	                             (step_q == STEP_LAST);
	assign blend_req.single    = loc_flags.single;
	assign blend_req.nodata_en = nodata_enable_q;

	brs_blend #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_blend (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (blend_req),
		.nodata_value (nodata_value_q),
		.z00          (z_q[0]),
		.z01          (z_q[1]),
		.z10          (z_q[2]),
		.z11          ($signed(rd_data)),
		.dx           (loc_dx),
		.dy           (loc_dy),
		.done         (blend_done),
		.result       (blend_res)
	);

	// The output register takes a finished result once it is empty or being read.
	assign out_load = (state_q == ST_RESULT) && (!m_tvalid_q || m_tready);

	// Query sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			z_q        <= '{default: '0};
			res_q      <= '0;
			out_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_q      <= res_q;
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (in_accept && (s_tuser == OP_QUERY)) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					if (loc_flags.oor) begin
						res_q.elevation <= oor_value_q;
						res_q.outcome   <= OUT_RANGE;
						state_q         <= ST_RESULT;
					end else begin
						if ((step_q != '0) && (step_q != STEP_LAST)) begin
							z_q[z_idx] <= $signed(rd_data);
						end
						if (step_q == STEP_LAST) begin
							state_q <= ST_BLEND;
						end else begin
							step_q <= step_q + 3'd1;
						end
					end
				end
				ST_BLEND: begin
					if (blend_done) begin
						res_q   <= blend_res;
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q.elevation;
	assign m_tuser  = out_q.outcome;

endmodule

### rtl/brs_checker.sv
// ----------------------------------------------------------------------------
// Bilinear raster sampler port checker
// Watches the stream ports of the sampler core over time; bound to the core.
// ----------------------------------------------------------------------------
`include "bilinear_raster_sampler_core_defines.svh"

module brs_checker
	import brs_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    s_tvalid,
	input logic                    s_tready,
	input logic                    s_tuser,
	input logic                    m_tvalid,
	input logic                    m_tready,
	input logic [M_TDATA_BITS-1:0] m_tdata,
	input logic [1:0]              m_tuser
);

	// A stalled result word stays offered.
	`BRS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result word dropped under stall")

	// A stalled result word keeps its contents.
	`BRS_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result word changed under stall")

	// A nodata outcome always carries a zero elevation.
	`BRS_ASSERT_NOW(a_nodata_zero, m_tvalid && (m_tuser == OUT_NODATA), m_tdata == '0, "nodata result with nonzero elevation")

	// A query takes the sequencer; the input closes in the next cycle.
	`BRS_ASSERT_NEXT(a_query_busy, s_tvalid && s_tready && (s_tuser == OP_QUERY), !s_tready, "input open right after a query")

endmodule

bind bilinear_raster_sampler_core brs_checker u_brs_checker (.*);

### tb/sv/bilinear_raster_sampler_core_tb.sv
// ----------------------------------------------------------------------------
// Bilinear raster sampler core testbench
// Loads raster samples and sends position queries over the input stream.
// Every query result is compared with its hand-typed value or else with an
// in-bench predictor that keeps its own copy of the raster and the registers.
// A directed table comes first, then random phases under several register
// settings. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module bilinear_raster_sampler_core_tb;
	import brs_pkg::*;

	localparam int MAX_COLS        = 256;
	localparam int MAX_ROWS        = 256;
	localparam int FRAC_BITS       = 8;
	localparam longint FIX_ONE     = 256;
	localparam longint FIX_HALF    = 128;
	localparam int SETTLE_CYCLES   = 16;
	localparam int TAIL_CYCLES     = 24;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int NUM_DIRECTED    = 24;

	// One input word plus an optional result typed in by hand.
	typedef struct packed {
		logic                           op;
		logic signed [POS_BITS-1:0]     pos_x;
		logic signed [POS_BITS-1:0]     pos_y;
		logic [COORD_BITS-1:0]          col;
		logic [COORD_BITS-1:0]          row;
		logic signed [WSAMPLE_BITS-1:0] sample;
		logic                           has_want;
		logic signed [ELEV_BITS-1:0]    want_elev;
		outcome_t                       want_code;
	} sampler_word_t;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} ready_mode_t;

	// Directed words: extreme samples, edge positions and out-of-range queries.
	localparam sampler_word_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		'{OP_WRITE, 18'sd0, 18'sd0, 8'd0, 8'd0, 24'sh7FFFFF, 1'b0, 24'sd0, OUT_INTERP},
		'{OP_WRITE, 18'sd0, 18'sd0, 8'd1, 8'd0, 24'sh800000, 1'b0, 24'sd0, OUT_INTERP},
		'{OP_WRITE, 18'sd0, 18'sd0, 8'd0, 8'd1, 24'sh800000, 1'b0, 24'sd0, OUT_INTERP},
		'{OP_WRITE, 18'sd0, 18'sd0, 8'd1, 8'd1, 24'sh7FFFFF, 1'b0, 24'sd0, OUT_INTERP},
		'{OP_WRITE, 18'sd0, 18'sd0, 8'd255, 8'd255, -24'sd1, 1'b0, 24'sd0, OUT_INTERP},
		'{OP_WRITE, 18'sd0, 18'sd0, 8'd254, 8'd255, 24'sd1000, 1'b0, 24'sd0, OUT_INTERP},
		'{OP_WRITE, 18'sd0, 18'sd0, 8'd255, 8'd254, -24'sd1000, 1'b0, 24'sd0, OUT_INTERP},
		'{OP_WRITE, 18'sd0, 18'sd0, 8'd254, 8'd254, 24'sd0, 1'b0, 24'sd0, OUT_INTERP},
		'{OP_QUERY, 18'sd0, 18'sd0, 8'd0, 8'd0, 24'sd0, 1'b1, 24'sh7FFFFF, OUT_INTERP},
		'{OP_QUERY, -18'sd128, -18'sd128, 8'd0, 8'd0, 24'sd0, 1'b1, 24'sh7FFFFF,
			OUT_SINGLE},
		'{OP_QUERY, 18'sd128, 18'sd128, 8'd0, 8'd0, 24'sd0, 1'b0, 24'sd0, OUT_INTERP},
		'{OP_QUERY, 18'sd64, 18'sd192, 8'd0, 8'd0, 24'sd0, 1'b0, 24'sd0, OUT_INTERP},
		'{OP_QUERY, -18'sd1, 18'sd200, 8'd0, 8'd0, 24'sd0, 1'b0, 24'sd0, OUT_INTERP},
		'{OP_QUERY, 18'sd65408, 18'sd65408, 8'd0, 8'd0, 24'sd0, 1'b1, -24'sd1,
			OUT_SINGLE},
		'{OP_QUERY, 18'sd65279, 18'sd65279, 8'd0, 8'd0, 24'sd0, 1'b0, 24'sd0, OUT_INTERP},
		'{OP_QUERY, -18'sd129, 18'sd0, 8'd0, 8'd0, 24'sd0, 1'b1, 24'sd0, OUT_RANGE},
		'{OP_QUERY, 18'sd0, -18'sd129, 8'd0, 8'd0, 24'sd0, 1'b1, 24'sd0, OUT_RANGE},
		'{OP_QUERY, 18'sd65409, 18'sd0, 8'd0, 8'd0, 24'sd0, 1'b1, 24'sd0, OUT_RANGE},
		'{OP_QUERY, 18'sd0, 18'sd65409, 8'd0, 8'd0, 24'sd0, 1'b1, 24'sd0, OUT_RANGE},
		'{OP_QUERY, 18'sh1FFFF, 18'sh20000, 8'd0, 8'd0, 24'sd0, 1'b1, 24'sd0, OUT_RANGE},
		'{OP_QUERY, 18'sh20000, 18'sh1FFFF, 8'd0, 8'd0, 24'sd0, 1'b1, 24'sd0, OUT_RANGE},
		'{OP_WRITE, 18'sd0, 18'sd0, 8'd0, 8'd0, 24'sd5, 1'b0, 24'sd0, OUT_INTERP},
		'{OP_QUERY, -18'sd128, -18'sd128, 8'd0, 8'd0, 24'sd0, 1'b1, 24'sd5, OUT_SINGLE},
		'{OP_QUERY, 18'sd32, 18'sd0, 8'd0, 8'd0, 24'sd0, 1'b0, 24'sd0, OUT_INTERP}
	};

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	// pos_x[17:0], pos_y[35:18], write_col[43:36], write_row[51:44],
	// write_sample[75:52], zero fill [79:76]
	logic [S_TDATA_BITS-1:0]  s_tdata;
	// op[0]
	logic                     s_tuser;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	// elevation[23:0]
	logic [M_TDATA_BITS-1:0]  m_tdata;
	// outcome[1:0]
	logic [1:0]               m_tuser;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [CFG_ADDR_BITS-1:0] paddr;
	logic [CFG_DATA_BITS-1:0] pwdata;
	logic [CFG_DATA_BITS-1:0] prdata;
	logic                     pready;

	// Predictor state: raster copy and register copy.
	logic signed [ELEV_BITS-1:0] elev_grid [MAX_COLS*MAX_ROWS];
	logic [SIZE_BITS-1:0]        cfg_cols;
	logic [SIZE_BITS-1:0]        cfg_rows;
	logic signed [ELEV_BITS-1:0] cfg_nodata;
	logic                        cfg_nodata_en;
	logic signed [ELEV_BITS-1:0] cfg_oor;

	// Entries written so far, tracked when words are planned.
	bit written_map [MAX_COLS*MAX_ROWS];

	sampler_word_t pending_words [$];
	result_t       expected_results [$];
	int            planned_words = 0;
	int            fail_count = 0;
	int unsigned   cycle_count = 0;
	ready_mode_t   stall_kind = READY_ALWAYS;
	int            stall_left = 0;

	bilinear_raster_sampler_core #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS),
		.FRAC_BITS(FRAC_BITS),
		.SAMPLE_BITS(WSAMPLE_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Cycle count and run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver ready follows a stall pattern that is itself chosen anew at random.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_kind = ready_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(16, 96);
		end
		stall_left = stall_left - 1;
		case (stall_kind)
			READY_ALWAYS: m_tready = 1'b1;
			STALL_LIGHT: m_tready = ($urandom_range(0, 3) != 0);
			STALL_HEAVY: m_tready = ($urandom_range(0, 4) == 0);
			default: m_tready = cycle_count[3];
		endcase
	end

	// Result words are compared with the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result word: elevation %0d, outcome %0d",
					$signed(m_tdata), m_tuser);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (m_tdata !== want.elevation) begin
					$error("elevation: expected %0d, got %0d", want.elevation,
						$signed(m_tdata));
					fail_count++;
				end
				if (m_tuser !== want.outcome) begin
					$error("outcome: expected %0d, got %0d", want.outcome, m_tuser);
					fail_count++;
				end
			end
		end
	end

	// A raster size register of zero acts as one, and one above the store as its size.
	function automatic longint used_size(input logic [SIZE_BITS-1:0] reg_val,
		input longint limit);
		if (reg_val == 0)
			return 1;
		if (reg_val > limit)
			return limit;
		return reg_val;
	endfunction

	function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Positions from minus one half to size minus one half lie on the raster.
	function automatic bit on_raster(input logic signed [POS_BITS-1:0] px,
		input logic signed [POS_BITS-1:0] py);
		longint x;
		longint y;
		longint w;
		longint h;
		x = px;
		y = py;
		w = used_size(cfg_cols, MAX_COLS);
		h = used_size(cfg_rows, MAX_ROWS);
		return !(x < -FIX_HALF || x > w * FIX_ONE - FIX_HALF ||
			y < -FIX_HALF || y > h * FIX_ONE - FIX_HALF);
	endfunction

	// Floor corner and next corner, both clamped to the raster.
	function automatic void corners_of(input logic signed [POS_BITS-1:0] px,
		input logic signed [POS_BITS-1:0] py, output longint x0, output longint x1,
		output longint y0, output longint y1);
		longint x;
		longint y;
		longint w;
		longint h;
		x = px;
		y = py;
		w = used_size(cfg_cols, MAX_COLS);
		h = used_size(cfg_rows, MAX_ROWS);
		x0 = x >>> FRAC_BITS;
		y0 = y >>> FRAC_BITS;
		x1 = clamp_to(x0 + 1, 0, w - 1);
		y1 = clamp_to(y0 + 1, 0, h - 1);
		x0 = clamp_to(x0, 0, w - 1);
		y0 = clamp_to(y0, 0, h - 1);
	endfunction

	// Expected result of one query under the current registers and raster.
	function automatic result_t sample_elevation(input logic signed [POS_BITS-1:0] px,
		input logic signed [POS_BITS-1:0] py);
		longint x0, x1, y0, y1, dx, dy;
		longint z00, z01, z10, z11, z0, z1, acc;
		result_t r;
		if (!on_raster(px, py)) begin
			r.elevation = cfg_oor;
			r.outcome = OUT_RANGE;
			return r;
		end
		corners_of(px, py, x0, x1, y0, y1);
		z00 = elev_grid[y0 * MAX_COLS + x0];
		z01 = elev_grid[y0 * MAX_COLS + x1];
		z10 = elev_grid[y1 * MAX_COLS + x0];
		z11 = elev_grid[y1 * MAX_COLS + x1];
		if (cfg_nodata_en && (z00 == cfg_nodata || z01 == cfg_nodata ||
			z10 == cfg_nodata || z11 == cfg_nodata)) begin
			r.elevation = '0;
			r.outcome = OUT_NODATA;
			return r;
		end
		if (x0 == x1 && y0 == y1) begin
			acc = z00;
			r.outcome = OUT_SINGLE;
		end else begin
			// Weights are taken from the clamped corner; each stage rounds half up.
			dx = px - x0 * FIX_ONE;
			dy = py - y0 * FIX_ONE;
			z0 = (z00 * (FIX_ONE - dx) + z01 * dx + FIX_HALF) >>> FRAC_BITS;
			z1 = (z10 * (FIX_ONE - dx) + z11 * dx + FIX_HALF) >>> FRAC_BITS;
			acc = (z0 * (FIX_ONE - dy) + z1 * dy + FIX_HALF) >>> FRAC_BITS;
			r.outcome = OUT_INTERP;
		end
		acc = clamp_to(acc, ELEV_MIN, ELEV_MAX);
		r.elevation = acc[ELEV_BITS-1:0];
		return r;
	endfunction

	function automatic logic [S_TDATA_BITS-1:0] pack_word(input sampler_word_t w);
		return {4'b0, w.sample, w.row, w.col, w.pos_y, w.pos_x};
	endfunction

	// An accepted word updates the raster copy or adds one expectation.
	function automatic void take_word(input sampler_word_t w);
		result_t r;
		if (w.op == OP_WRITE) begin
			elev_grid[int'(w.row) * MAX_COLS + int'(w.col)] = w.sample;
		end else if (w.has_want) begin
			r.elevation = w.want_elev;
			r.outcome = w.want_code;
			expected_results = {expected_results, r};
		end else begin
			r = sample_elevation(w.pos_x, w.pos_y);
			expected_results = {expected_results, r};
		end
	endfunction

	function automatic void plan_word(input sampler_word_t w);
		if (w.op == OP_WRITE)
			written_map[int'(w.row) * MAX_COLS + int'(w.col)] = 1'b1;
		pending_words = {pending_words, w};
		planned_words++;
	endfunction

	function automatic logic signed [ELEV_BITS-1:0] random_elev();
		case ($urandom_range(0, 7))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return cfg_nodata;
			3, 4: return 24'(int'($urandom_range(0, 2000)) - 1000);
			default: return 24'($urandom());
		endcase
	endfunction

	function automatic void plan_write(input longint col, input longint row,
		input logic signed [ELEV_BITS-1:0] value);
		sampler_word_t w;
		w = '0;
		w.op = OP_WRITE;
		w.pos_x = 18'($urandom());
		w.pos_y = 18'($urandom());
		w.col = col[COORD_BITS-1:0];
		w.row = row[COORD_BITS-1:0];
		w.sample = value;
		plan_word(w);
	endfunction

	// Coordinate on the raster along one axis, edges favored.
	function automatic logic signed [POS_BITS-1:0] coord_on(input longint size);
		case ($urandom_range(0, 5))
			0: return -18'sd128;
			1: return 18'(size * FIX_ONE - FIX_HALF);
			2: return 18'(longint'($urandom_range(0, 32'(size - 1))) * FIX_ONE);
			default: return 18'(longint'($urandom_range(0, 32'(size * FIX_ONE))) - FIX_HALF);
		endcase
	endfunction

	// Coordinate just off the raster, or anywhere in the field's range.
	function automatic logic signed [POS_BITS-1:0] coord_off(input longint size);
		case ($urandom_range(0, 2))
			0: return -18'sd129;
			1: return 18'(size * FIX_ONE - FIX_HALF + 1);
			default: return 18'($urandom());
		endcase
	endfunction

	// A query, preceded by writes of any corner not yet loaded and now and then
	// by a nodata sample on one corner.
	function automatic void plan_query(input bit off_raster);
		sampler_word_t q;
		longint w, h;
		longint x0, x1, y0, y1;
		longint cx [4];
		longint cy [4];
		int pick;
		w = used_size(cfg_cols, MAX_COLS);
		h = used_size(cfg_rows, MAX_ROWS);
		q = '0;
		q.op = OP_QUERY;
		q.col = 8'($urandom());
		q.row = 8'($urandom());
		q.sample = 24'($urandom());
		if (!off_raster) begin
			q.pos_x = coord_on(w);
			q.pos_y = coord_on(h);
		end else if ($urandom_range(0, 1) == 0) begin
			q.pos_x = coord_off(w);
			q.pos_y = coord_on(h);
		end else begin
			q.pos_x = coord_on(w);
			q.pos_y = coord_off(h);
		end
		if (on_raster(q.pos_x, q.pos_y)) begin
			corners_of(q.pos_x, q.pos_y, x0, x1, y0, y1);
			cx = '{x0, x1, x0, x1};
			cy = '{y0, y0, y1, y1};
			for (int i = 0; i < 4; i++) begin
				if (!written_map[cy[i] * MAX_COLS + cx[i]])
					plan_write(cx[i], cy[i], random_elev());
			end
			if ($urandom_range(0, 5) == 0) begin
				pick = $urandom_range(0, 3);
				plan_write(cx[pick], cy[pick], cfg_nodata);
			end
		end
		plan_word(q);
	endfunction

	// Random mix of sample loads and queries, mostly on the raster.
	function automatic void plan_random(input int count);
		int stop_at;
		int kind;
		longint w, h;
		stop_at = planned_words + count;
		w = used_size(cfg_cols, MAX_COLS);
		h = used_size(cfg_rows, MAX_ROWS);
		while (planned_words < stop_at) begin
			kind = $urandom_range(0, 19);
			if (kind < 3)
				plan_write($urandom_range(0, 255), $urandom_range(0, 255), random_elev());
			else if (kind < 7)
				plan_write($urandom_range(0, 32'(w - 1)), $urandom_range(0, 32'(h - 1)),
					random_elev());
			else if (kind < 17)
				plan_query(1'b0);
			else
				plan_query(1'b1);
		end
	endfunction

	// Sends all planned words in bursts with random gaps.
	task automatic send_words();
		sampler_word_t w;
		int burst;
		int gap;
		while (pending_words.size() != 0) begin
			burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			while (burst > 0 && pending_words.size() != 0) begin
				w = pending_words.pop_front();
				@(negedge clk);
				s_tvalid = 1'b1;
				s_tdata = pack_word(w);
				s_tuser = w.op;
				@(posedge clk);
				while (!s_tready)
					@(posedge clk);
				take_word(w);
				burst--;
			end
			gap = $urandom_range(0, 5);
			if (gap != 0) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic wait_results();
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Register write: setup cycle, then access cycle; pready is always high.
	task automatic write_reg(input logic [2:0] index, input logic [CFG_DATA_BITS-1:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {index, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		case (index)
			REG_WIDTH: cfg_cols = value[SIZE_BITS-1:0];
			REG_HEIGHT: cfg_rows = value[SIZE_BITS-1:0];
			REG_NODATA_VALUE: cfg_nodata = value[ELEV_BITS-1:0];
			REG_NODATA_ENABLE: cfg_nodata_en = value[0];
			REG_OOR_VALUE: cfg_oor = value[ELEV_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Registers change only once the block has gone quiet.
	task automatic set_raster(input logic [SIZE_BITS-1:0] cols,
		input logic [SIZE_BITS-1:0] rows, input logic signed [ELEV_BITS-1:0] nodata,
		input logic nodata_en, input logic signed [ELEV_BITS-1:0] oor);
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_WIDTH, 32'(cols));
		write_reg(REG_HEIGHT, 32'(rows));
		write_reg(REG_NODATA_VALUE, 32'(nodata));
		write_reg(REG_NODATA_ENABLE, 32'(nodata_en));
		write_reg(REG_OOR_VALUE, 32'(oor));
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_WRITE;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_cols = RST_WIDTH;
		cfg_rows = RST_HEIGHT;
		cfg_nodata = RST_NODATA;
		cfg_nodata_en = RST_NODATA_EN;
		cfg_oor = RST_OOR_VALUE;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table under the reset register values.
		for (int i = 0; i < NUM_DIRECTED; i++)
			plan_word(DIRECTED_ROWS[i]);
		send_words();

		// Random words at full size, with one full drain in the middle.
		plan_random(100);
		send_words();
		wait_results();
		plan_random(100);
		send_words();

		// Zero width acts as one column, oversize height as the full store.
		set_raster(9'd0, 9'd511, 24'($urandom()), 1'b1, 24'sh800000);
		plan_random(125);
		send_words();

		// Small raster with nodata at the top of the range.
		set_raster(9'd5, 9'd3, 24'sh7FFFFF, 1'b1, 24'sh7FFFFF);
		plan_random(125);
		send_words();

		// One row, oversize width, nodata detection off.
		set_raster(9'd300, 9'd1, 24'sh800000, 1'b0, 24'($urandom()));
		plan_random(125);
		send_words();

		// Random size and values.
		set_raster(9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)),
			24'(int'($urandom_range(0, 2000)) - 1000), 1'b1, 24'($urandom()));
		plan_random(125);
		send_words();

		wait_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/brs_pkg.sv
rtl/brs_store.sv
rtl/brs_locate.sv
rtl/brs_blend.sv
rtl/bilinear_raster_sampler_core.sv
rtl/brs_checker.sv
tb/sv/bilinear_raster_sampler_core_tb.sv
